[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and controller/datapath signal groups for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0A;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [15:0] cell_data;
  } result_t;

  typedef struct packed {
    logic load;
    logic put_write;
    logic advance;
    logic read;
    logic sweep_start;
    logic scroll_step;
    logic clear_step;
    logic init_step;
    logic cursor_home;
    logic cursor_bottom;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_newline;
    logic       wrap_scroll;
    logic       sweep_last;
    logic       sweep_end;
  } status_t;

endpackage

[rtl/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, attribute register, sweep counter and result data.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcw_pkg::item_t  item_i,
  input  logic            attr_we_i,
  input  logic [7:0]      attr_wdata_i,
  input  tcw_pkg::cmd_t   cmd_i,
  output tcw_pkg::status_t status_o,
  output tcw_pkg::result_t result_o
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = $clog2(ROWS);
  localparam int MOVED = CELLS - COLUMNS;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_q;
  logic          data_sel_q;
  logic [7:0]    attr_q;
  item_t         item_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [SW-1:0] sweep_q;

  logic          idx_ok;
  logic [AW-1:0] pos;
  logic          col_last;
  logic          row_last;
  logic          scroll_rd;
  logic [AW-1:0] raddr;
  logic          re;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   blank;

  assign blank    = {attr_q, BLANK_CODE};
  assign idx_ok   = 32'(item_q.cell_index) < 32'(CELLS);
  assign pos      = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
  assign col_last = (col_q == CW'(COLUMNS - 1));
  assign row_last = (row_q == RW'(ROWS - 1));
  assign scroll_rd = (sweep_q < SW'(MOVED));

  assign status_o.func        = item_q.func;
  assign status_o.is_newline  = (item_q.char_code == NEWLINE_CODE);
  assign status_o.wrap_scroll = col_last && row_last;
  assign status_o.sweep_last  = (sweep_q == SW'(CELLS - 1));
  assign status_o.sweep_end   = (sweep_q == SW'(CELLS));

  assign result_o.cursor_location = 11'(pos);
  assign result_o.cell_data       = data_sel_q ? rd_q : 16'h0000;

  always_comb begin
    re    = 1'b0;
    raddr = AW'(sweep_q + SW'(COLUMNS));
    if (cmd_i.read) begin
      raddr = AW'(item_q.cell_index);
      re    = idx_ok;
    end else if (cmd_i.scroll_step) begin
      re = scroll_rd;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(sweep_q);
    wdata = blank;
    priority if (cmd_i.put_write) begin
      we    = 1'b1;
      waddr = pos;
      wdata = {attr_q, item_q.char_code};
    end else if (cmd_i.scroll_step) begin
      we    = (sweep_q != '0);
      waddr = AW'(sweep_q - SW'(1));
      wdata = (sweep_q <= SW'(MOVED)) ? rd_q : blank;
    end else if (cmd_i.clear_step) begin
      we = 1'b1;
    end else if (cmd_i.init_step) begin
      we    = 1'b1;
      wdata = {ATTR_RESET, BLANK_CODE};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q     <= ATTR_RESET;
      col_q      <= '0;
      row_q      <= RW'(ROWS - 1);
      sweep_q    <= '0;
      data_sel_q <= 1'b0;
    end else begin
      if (attr_we_i) begin
        attr_q <= attr_wdata_i;
      end
      if (cmd_i.sweep_start) begin
        sweep_q <= '0;
      end else if (cmd_i.scroll_step || cmd_i.clear_step || cmd_i.init_step) begin
        sweep_q <= sweep_q + SW'(1);
      end
      if (cmd_i.cursor_home) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.cursor_bottom) begin
        col_q <= '0;
        row_q <= RW'(ROWS - 1);
      end else if (cmd_i.advance) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        data_sel_q <= cmd_i.read && idx_ok;
      end
    end
  end

endmodule

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the text console writer: decode, scroll, clear and the
// post-reset fill of the cell store.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_SCROLL,
    S_CLEAR
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.func)
          FUNC_PUT: begin
            if (status_i.is_newline) begin
              cmd_o.sweep_start = 1'b1;
              state_d           = S_SCROLL;
            end else begin
              cmd_o.put_write = 1'b1;
              cmd_o.advance   = 1'b1;
              if (status_i.wrap_scroll) begin
                cmd_o.sweep_start = 1'b1;
                state_d           = S_SCROLL;
              end else begin
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end
            end
          end
          FUNC_CLEAR: begin
            cmd_o.sweep_start = 1'b1;
            state_d           = S_CLEAR;
          end
          FUNC_READ: begin
            cmd_o.read   = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (status_i.sweep_end) begin
          cmd_o.cursor_bottom = 1'b1;
          cmd_o.finish        = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.cursor_home = 1'b1;
          cmd_o.finish      = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

endmodule

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine: ROWS x COLUMNS cell store with cursor, put-char,
// newline scroll, clear and single-cell read.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// is shown on result_o while result_valid_o is high for a single cycle, and
// cannot be held off. After reset the block fills the cell store with blanks,
// one cell per cycle, and stays busy until all ROWS*COLUMNS cells (2000 by
// default) are written. Put of an ordinary character, read and the unused
// code pass from S_IDLE through S_DECODE back to S_IDLE, and no new
// transaction is taken before that. Clear and newline, or a put that wraps
// past the last row, walk the whole store through its single write port,
// one cell per cycle. The attribute register may be written at any
// time the block is idle and takes effect on the next transaction.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item_i,
  output logic             result_valid_o,
  output tcw_pkg::result_t result_o,
  input  logic             text_attribute_we_i,
  input  logic [7:0]       text_attribute_i
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (result_valid_o)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .attr_we_i    (text_attribute_we_i),
    .attr_wdata_i (text_attribute_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .result_o     (result_o)
  );

endmodule

[sim/tb_text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Self-checking bench for the text console writer. Commands are driven
// through the start/busy handshake with random gaps. A shadow copy of the
// cell store, cursor and attribute computes each expected result. Every
// result is compared field by field in arrival order. Directed tests cover
// the power-on screen, put, newline, clear, the attribute extremes,
// out-of-range reads and the unused code. Random traffic follows in phases,
// with a new attribute before each phase.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int COLUMNS    = COLUMNS_DEFAULT;
  localparam int ROWS       = ROWS_DEFAULT;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int SWEEP_WAIT = CELL_COUNT + 16;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 206;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;
  logic    text_attribute_we_i;
  logic [7:0] text_attribute_i;

  logic [15:0] shadow_cells [CELL_COUNT];
  int          shadow_col;
  int          shadow_row;
  logic [7:0]  shadow_attr;

  result_t pending_results [$];
  int      mismatch_count;
  int      transactions_sent;
  int      results_checked;
  int      sweeps_predicted;
  int      reads_in_range;
  bit      no_gaps;

  text_console_writer_top i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .item_i              (item_i),
    .result_valid_o      (result_valid_o),
    .result_o            (result_o),
    .text_attribute_we_i (text_attribute_we_i),
    .text_attribute_i    (text_attribute_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #150_000_000;
    $display("tb_text_console_writer_top failed");
    $finish;
  end

  // Shadow of the console
  function automatic logic [15:0] blank_word();
    return {shadow_attr, BLANK_CODE};
  endfunction

  function automatic void scroll_shadow();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
      shadow_cells[i] = shadow_cells[i + COLUMNS];
    end
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
      shadow_cells[i] = blank_word();
    end
    shadow_col = 0;
    shadow_row = ROWS - 1;
    sweeps_predicted++;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < CELL_COUNT; i++) begin
      shadow_cells[i] = blank_word();
    end
    shadow_col = 0;
    shadow_row = 0;
    sweeps_predicted++;
  endfunction

  function automatic void put_shadow(input logic [7:0] code);
    if (code == NEWLINE_CODE) begin
      scroll_shadow();
    end else begin
      shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
      shadow_col++;
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS) begin
          scroll_shadow();
        end
      end
    end
  endfunction

  function automatic result_t console_apply(input item_t it);
    result_t res;
    res.cell_data = '0;
    case (it.func)
      FUNC_PUT: put_shadow(it.char_code);
      FUNC_CLEAR: clear_shadow();
      FUNC_READ: begin
        if (it.cell_index < CELL_COUNT) begin
          res.cell_data = shadow_cells[it.cell_index];
          reads_in_range++;
        end
      end
      default: ;
    endcase
    res.cursor_location = 11'(shadow_row * COLUMNS + shadow_col);
    return res;
  endfunction

  // Stimulus helpers
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_results.push_back(console_apply(it));
    transactions_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [1:0] func, input logic [7:0] code,
                             input logic [10:0] index);
    item_t it;
    it.func       = func;
    it.char_code  = code;
    it.cell_index = index;
    send_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic set_text_attribute(input logic [7:0] value);
    wait_idle();
    text_attribute_we_i <= 1'b1;
    text_attribute_i    <= value;
    @(negedge clk_i);
    text_attribute_we_i <= 1'b0;
    shadow_attr = value;
  endtask

  function automatic item_t random_transaction();
    item_t it;
    int pick;
    it.func       = FUNC_PUT;
    it.char_code  = 8'($urandom_range(0, 255));
    it.cell_index = 11'($urandom_range(0, 2047));
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      it.func = FUNC_CLEAR;
    end else if (pick < 6) begin
      it.char_code = NEWLINE_CODE;
    end else if (pick < 8) begin
      it.func = FUNC_UNUSED;
    end else if (pick < 24) begin
      it.func = FUNC_READ;
      if (pick < 16) begin
        it.cell_index = 11'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
      end
    end
    return it;
  endfunction

  // Result checking
  task automatic log_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected transaction", 0, int'(result_o));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_o.cursor_location !== want.cursor_location) begin
          log_mismatch("cursor_location", int'(want.cursor_location),
                       int'(result_o.cursor_location));
        end
        if (result_o.cell_data !== want.cell_data) begin
          log_mismatch("cell_data", int'(want.cell_data), int'(result_o.cell_data));
        end
      end
    end
  end

  // Tests
  task automatic test_power_on_state();
    send_fields(FUNC_READ, 8'h00, 11'd0);
    send_fields(FUNC_READ, 8'hFF, 11'(CELL_COUNT - 1));
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT));
    send_fields(FUNC_READ, 8'h00, 11'h7FF);
    send_fields(FUNC_UNUSED, 8'hFF, 11'h7FF);
    wait_idle();
  endtask

  task automatic test_put_and_newline();
    send_fields(FUNC_PUT, 8'h00, 11'h7FF);
    send_fields(FUNC_PUT, 8'hFF, 11'd0);
    send_fields(FUNC_PUT, 8'h41, 11'd5);
    send_fields(FUNC_READ, 8'h0A, 11'(CELL_COUNT - COLUMNS));
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT - COLUMNS + 2));
    send_fields(FUNC_PUT, NEWLINE_CODE, 11'h7FF);
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT - 2 * COLUMNS + 1));
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT - COLUMNS));
    wait_idle();
  endtask

  task automatic test_clear_and_attribute();
    set_text_attribute(8'hFF);
    send_fields(FUNC_CLEAR, NEWLINE_CODE, 11'h7FF);
    send_fields(FUNC_READ, 8'hFF, 11'd0);
    send_fields(FUNC_PUT, 8'h55, 11'd1999);
    send_fields(FUNC_READ, 8'h00, 11'd0);
    set_text_attribute(8'h00);
    send_fields(FUNC_PUT, NEWLINE_CODE, 11'd0);
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT - 1));
    send_fields(FUNC_READ, 8'h00, 11'(CELL_COUNT - COLUMNS - 1));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_text_attribute(8'h00);
        1: set_text_attribute(8'hFF);
        default: set_text_attribute(8'($urandom_range(0, 255)));
      endcase
      no_gaps = (phase % 3 == 2);
      repeat (PHASE_ITEMS) send_item(random_transaction());
      wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni              = 1'b0;
    start               = 1'b0;
    item_i              = '0;
    text_attribute_we_i = 1'b0;
    text_attribute_i    = '0;
    mismatch_count      = 0;
    transactions_sent   = 0;
    results_checked     = 0;
    sweeps_predicted    = 0;
    reads_in_range      = 0;
    no_gaps             = 1'b0;
    shadow_attr         = ATTR_RESET;
    for (int i = 0; i < CELL_COUNT; i++) begin
      shadow_cells[i] = blank_word();
    end
    shadow_col = 0;
    shadow_row = ROWS - 1;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_power_on_state();
    test_put_and_newline();
    test_clear_and_attribute();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SWEEP_WAIT) @(posedge clk_i);

    $display("Sent %0d transactions and checked %0d results, %0d of them reads in range.",
             transactions_sent, results_checked, reads_in_range);
    $display("Screen sweeps from clear, newline and wrap: %0d; mismatches: %0d.",
             sweeps_predicted, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_text_console_writer_top passed");
    end else begin
      $display("tb_text_console_writer_top failed");
    end
    $finish;
  end

endmodule
